[rtl/lwsm_pkg.sv]
// Package for the latest-window slot manager.
// Holds slot constants, request and status codes, item structs and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package lwsm_pkg;

  localparam int SLOTS = 4;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [4:0] SLOTS_V = 5'(SLOTS);

  localparam logic [2:0] REQ_BEGIN   = 3'd0;
  localparam logic [2:0] REQ_PUBLISH = 3'd1;
  localparam logic [2:0] REQ_ACQUIRE = 3'd2;
  localparam logic [2:0] REQ_RELEASE = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;

  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_WRITING = 2'd1;
  localparam logic [1:0] ST_READY   = 2'd2;
  localparam logic [1:0] ST_READING = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  slot_sel;
    logic [63:0] stamp_in;
  } req_item_t;

  typedef struct packed {
    logic        granted;
    logic [1:0]  slot_out;
    logic [63:0] stamp_out;
  } res_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic find_step;
    logic sweep_step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_acquire;
    logic last_idx;
  } ctl_sts_t;

endpackage

[rtl/lwsm_ctrl.sv]
// Controller for the latest-window slot manager.
// Sequences the exec step of every request and the two slot scans of acquire; uses lwsm_pkg.
`timescale 1ns / 1ps

module lwsm_ctrl
  import lwsm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_strobe,
  output ctl_cmd_t cmd,
  input  ctl_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_SWEEP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_strobe_r;

  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == S_IDLE) && start;
    cmd.exec       = (state_r == S_EXEC);
    cmd.find_step  = (state_r == S_FIND);
    cmd.sweep_step = (state_r == S_SWEEP);
    cmd.finish     = cmd.exec || (cmd.sweep_step && sts.last_idx);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // acquire needs the scan; everything else is done here
        if (sts.is_acquire) state_nxt = S_FIND;
        else state_nxt = S_IDLE;
      end
      S_FIND: begin
        if (sts.last_idx) state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (sts.last_idx) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= cmd.finish && !(cmd.exec && sts.is_acquire);
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;

endmodule

[rtl/lwsm_dpath.sv]
// Datapath for the latest-window slot manager: slot status and stamps,
// request hold register, acquire scan registers and result register; uses lwsm_pkg.
`timescale 1ns / 1ps

module lwsm_dpath
  import lwsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  req_item_t in_item,
  input  ctl_cmd_t  cmd,
  output ctl_sts_t  sts,
  output res_item_t out_item
);

  logic [1:0]       status_r [SLOTS];
  logic [1:0]       status_nxt [SLOTS];
  logic [63:0]      stamp_r [SLOTS];
  logic [63:0]      stamp_nxt [SLOTS];
  req_item_t        req_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic [63:0]      best_stamp_r, best_stamp_nxt;
  res_item_t        res_r, res_nxt;

  logic             last;
  logic             sel_ok;
  logic [IDX_W-1:0] sel_idx;
  logic             free_hit;
  logic [IDX_W-1:0] free_idx;
  logic [1:0]       cur_status;
  logic [63:0]      cur_stamp;

  assign last       = (idx_r == IDX_W'(SLOTS - 1));
  assign sel_ok     = ({3'b000, req_r.slot_sel} < SLOTS_V);
  assign sel_idx    = IDX_W'(req_r.slot_sel);
  assign cur_status = status_r[idx_r];
  assign cur_stamp  = stamp_r[idx_r];

  // lowest free slot
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (status_r[i] == ST_FREE) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    status_nxt     = status_r;
    stamp_nxt      = stamp_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_stamp_nxt = best_stamp_r;
    res_nxt        = res_r;

    if (cmd.load) begin
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end

    if (cmd.exec) begin
      res_nxt = '0;
      case (req_r.req_type)
        REQ_BEGIN: begin
          if (free_hit) begin
            status_nxt[free_idx] = ST_WRITING;
            res_nxt.granted      = 1'b1;
            res_nxt.slot_out     = 2'(free_idx);
          end
        end
        REQ_PUBLISH: begin
          if (sel_ok) begin
            status_nxt[sel_idx] = ST_READY;
            stamp_nxt[sel_idx]  = req_r.stamp_in;
            res_nxt.granted     = 1'b1;
          end
        end
        REQ_RELEASE: begin
          if (sel_ok) begin
            status_nxt[sel_idx] = ST_FREE;
            res_nxt.granted     = 1'b1;
          end
        end
        REQ_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) begin
            status_nxt[i] = ST_FREE;
            stamp_nxt[i]  = '0;
          end
          res_nxt.granted = 1'b1;
        end
        default: res_nxt = '0;
      endcase
    end

    // pass one: keep the first ready slot with the greatest stamp
    if (cmd.find_step) begin
      if (cur_status == ST_READY && (!found_r || cur_stamp > best_stamp_r)) begin
        found_nxt      = 1'b1;
        best_nxt       = idx_r;
        best_stamp_nxt = cur_stamp;
      end
      idx_nxt = last ? '0 : idx_r + 1'b1;
    end

    // pass two: claim the winner, drop older ready slots
    if (cmd.sweep_step) begin
      if (found_r) begin
        if (idx_r == best_r) begin
          status_nxt[idx_r] = ST_READING;
        end else if (cur_status == ST_READY && cur_stamp < best_stamp_r) begin
          status_nxt[idx_r] = ST_FREE;
        end
      end
      idx_nxt = last ? '0 : idx_r + 1'b1;
      if (cmd.finish) begin
        res_nxt.granted   = found_r;
        res_nxt.slot_out  = found_r ? 2'(best_r) : 2'b00;
        res_nxt.stamp_out = found_r ? best_stamp_r : 64'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        status_r[i] <= ST_FREE;
        stamp_r[i]  <= '0;
      end
      idx_r   <= '0;
      found_r <= 1'b0;
    end else begin
      status_r <= status_nxt;
      stamp_r  <= stamp_nxt;
      idx_r    <= idx_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_item;
    best_r       <= best_nxt;
    best_stamp_r <= best_stamp_nxt;
    res_r        <= res_nxt;
  end

  assign sts.is_acquire = (req_r.req_type == REQ_ACQUIRE);
  assign sts.last_idx   = last;
  assign out_item       = res_r;

endmodule

[rtl/latest_window_slot_manager.sv]
// Top level of the latest-window slot manager.
// Joins lwsm_ctrl and lwsm_dpath; uses lwsm_pkg.
//
// Usage:
//   Requests arrive on in_item and are taken at a rising edge where start is
//   high and busy is low. Each request yields exactly one result on out_item,
//   shown for one cycle with out_strobe high; the receiver cannot stall it.
//   Begin write, publish, release, clear and unknown codes are executed in the
//   EXEC state, and the result and out_strobe are then registered. Acquire
//   latest goes on from EXEC: the controller walks the slots once to find the
//   newest ready stamp, one 64-bit compare per cycle, then once more to mark
//   the winner reading and free older ready slots. busy falls in the strobe
//   cycle, so a new request can be taken while a result is shown.
//   Reset (rst_n low, synchronous) frees every slot, zeroes all stamps and
//   returns the controller to idle with no strobe pending.
`timescale 1ns / 1ps

module latest_window_slot_manager
  import lwsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  req_item_t in_item,
  output logic      out_strobe,
  output res_item_t out_item
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  lwsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .sts        (sts)
  );

  lwsm_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but controller not busy");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("strobe without a request in progress");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.granted) |->
      (out_item.slot_out == 2'b00 && out_item.stamp_out == 64'd0))
    else $error("refused result carries nonzero fields");

endmodule
